>>> rtl/lbp3u_pkg.sv
// ----------------------------------------------------------------------------
// lbp3u_pkg
// Shared types, register codes and the uniform label table for the 3x3 LBP
// label stream unit.
// ----------------------------------------------------------------------------
package lbp3u_pkg;

  localparam int PIXEL_W      = 8;
  localparam int LABEL_W      = 8;
  localparam int ROW_W        = 12;
  localparam int COL_W        = 10;
  localparam int WIDTH_W      = 11;
  localparam int HEIGHT_W     = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 2;
  localparam int LINE_WORD_W  = 2 * PIXEL_W;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;
  localparam int QCOUNT_W     = 3;
  localparam int TABLE_SIZE   = 256;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_UNIFORM_MODE = 2'd2;

  typedef struct packed {
    logic produce;
    logic frame_done;
  } scan_flags_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [ROW_W-1:0]   center_row;
    logic [COL_W-1:0]   center_col;
    logic               frame_done;
  } result_t;

  typedef logic [LABEL_W-1:0] label_table_t [TABLE_SIZE];

  // Uniform patterns (at most two circular transitions) numbered 1..58 in
  // ascending code order; everything else maps to 0.
  function automatic label_table_t build_label_table();
    label_table_t tbl;
    logic [7:0]   code;
    logic [7:0]   rot;
    logic [7:0]   next_label;
    next_label = 8'd1;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      code = 8'(i);
      rot  = {code[6:0], code[7]};
      if ($countones(code ^ rot) <= 2) begin
        tbl[i]     = next_label;
        next_label = next_label + 8'd1;
      end else begin
        tbl[i] = 8'd0;
      end
    end
    return tbl;
  endfunction

  localparam label_table_t LABEL_TABLE = build_label_table();

endpackage

>>> rtl/lbp3u_pixel_if.sv
// ----------------------------------------------------------------------------
// lbp3u_pixel_if
// Pixel stream channel: valid/ready handshake with pixel and frame_start.
// ----------------------------------------------------------------------------
interface lbp3u_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [lbp3u_pkg::PIXEL_W-1:0] pixel;
  logic                          frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

>>> rtl/lbp3u_label_if.sv
// ----------------------------------------------------------------------------
// lbp3u_label_if
// Label result channel: valid/ready handshake with label and position.
// ----------------------------------------------------------------------------
interface lbp3u_label_if;
  logic                          valid;
  logic                          ready;
  logic [lbp3u_pkg::LABEL_W-1:0] label;
  logic [lbp3u_pkg::ROW_W-1:0]   center_row;
  logic [lbp3u_pkg::COL_W-1:0]   center_col;
  logic                          frame_done;

  modport source (output valid, output label, output center_row,
                  output center_col, output frame_done, input ready);
  modport sink   (input valid, input label, input center_row,
                  input center_col, input frame_done, output ready);
endinterface

>>> rtl/lbp3u_line_mem.sv
// ----------------------------------------------------------------------------
// lbp3u_line_mem
// Line store: one word per column holding {upper, middle} pixels. Synchronous
// read with a registered output; a read that meets a write to the same
// column returns the new data.
// ----------------------------------------------------------------------------
module lbp3u_line_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [ADDR_W-1:0]                 wr_addr,
  input  logic [lbp3u_pkg::LINE_WORD_W-1:0] wr_data,
  input  logic                              rd_en,
  input  logic [ADDR_W-1:0]                 rd_addr,
  output logic [lbp3u_pkg::LINE_WORD_W-1:0] rd_data
);

  logic [lbp3u_pkg::LINE_WORD_W-1:0] mem [DEPTH];
  logic [lbp3u_pkg::LINE_WORD_W-1:0] mem_q;
  logic [lbp3u_pkg::LINE_WORD_W-1:0] bypass_data;
  logic                              bypass;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q       <= mem[rd_addr];
      bypass_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass <= 1'b0;
    end else if (rd_en) begin
      bypass <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = bypass ? bypass_data : mem_q;

endmodule

>>> rtl/lbp3u_scan.sv
// ----------------------------------------------------------------------------
// lbp3u_scan
// Raster position tracker: row/column counters, border and end-of-image flags.
// ----------------------------------------------------------------------------
module lbp3u_scan #(
  parameter int MAX_WIDTH = 1024,
  parameter int ADDR_W    = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic                             frame_start,
  input  logic [lbp3u_pkg::WIDTH_W-1:0]    image_width,
  input  logic [lbp3u_pkg::HEIGHT_W-1:0]   image_height,
  output logic [ADDR_W-1:0]                col,
  output lbp3u_pkg::scan_flags_t           flags,
  output logic [lbp3u_pkg::ROW_W-1:0]      center_row,
  output logic [lbp3u_pkg::COL_W-1:0]      center_col
);

  localparam int CW = (ADDR_W + 1 > lbp3u_pkg::WIDTH_W) ? ADDR_W + 1 : lbp3u_pkg::WIDTH_W;

  logic [lbp3u_pkg::ROW_W-1:0] row_position, row_position_next;
  logic [ADDR_W-1:0]           column_position, column_position_next;
  logic [lbp3u_pkg::ROW_W-1:0] r;
  logic [ADDR_W-1:0]           c;
  logic [CW-1:0]               wcfg;
  logic [ADDR_W-1:0]           last_col;
  logic [lbp3u_pkg::ROW_W-1:0] last_row;
  logic                        row_end;
  logic                        image_end;

  // clamp width to 3..MAX_WIDTH, height to 3..HEIGHT_LIMIT
  always_comb begin
    wcfg = CW'(image_width);
    if (wcfg < CW'(3)) begin
      last_col = ADDR_W'(2);
    end else if (wcfg >= CW'(MAX_WIDTH)) begin
      last_col = ADDR_W'(MAX_WIDTH - 1);
    end else begin
      last_col = ADDR_W'(wcfg - CW'(1));
    end
    if (image_height < lbp3u_pkg::HEIGHT_W'(3)) begin
      last_row = lbp3u_pkg::ROW_W'(2);
    end else if (image_height >= lbp3u_pkg::HEIGHT_W'(lbp3u_pkg::HEIGHT_LIMIT)) begin
      last_row = lbp3u_pkg::ROW_W'(lbp3u_pkg::HEIGHT_LIMIT - 1);
    end else begin
      last_row = lbp3u_pkg::ROW_W'(image_height - lbp3u_pkg::HEIGHT_W'(1));
    end
  end

  always_comb begin
    r         = frame_start ? '0 : row_position;
    c         = frame_start ? '0 : column_position;
    row_end   = c >= last_col;
    image_end = r >= last_row;

    flags.produce    = (r >= lbp3u_pkg::ROW_W'(2)) && (c >= ADDR_W'(2));
    flags.frame_done = image_end && row_end;
    center_row       = r - lbp3u_pkg::ROW_W'(1);
    center_col       = lbp3u_pkg::COL_W'(c - ADDR_W'(1));
    col              = c;

    if (row_end) begin
      column_position_next = '0;
      row_position_next    = image_end ? '0 : r + lbp3u_pkg::ROW_W'(1);
    end else begin
      column_position_next = c + ADDR_W'(1);
      row_position_next    = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_position    <= '0;
      column_position <= '0;
    end else if (accept) begin
      row_position    <= row_position_next;
      column_position <= column_position_next;
    end
  end

endmodule

>>> rtl/lbp3u_window.sv
// ----------------------------------------------------------------------------
// lbp3u_window
// Stage 1 takes the line store read, updates the 3x3 window, writes the
// column back and forms the 8-bit code; stage 2 holds the code.
// ----------------------------------------------------------------------------
module lbp3u_window #(
  parameter int ADDR_W = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [lbp3u_pkg::PIXEL_W-1:0]     in_pixel,
  input  logic [ADDR_W-1:0]                 in_col,
  input  lbp3u_pkg::scan_flags_t            in_flags,
  input  logic [lbp3u_pkg::ROW_W-1:0]       in_center_row,
  input  logic [lbp3u_pkg::COL_W-1:0]       in_center_col,
  input  logic [lbp3u_pkg::LINE_WORD_W-1:0] mem_rd_data,
  output logic                              mem_wr_en,
  output logic [ADDR_W-1:0]                 mem_wr_addr,
  output logic [lbp3u_pkg::LINE_WORD_W-1:0] mem_wr_data,
  output logic                              s1_busy,
  output logic                              out_valid,
  output logic [7:0]                        out_code,
  output logic [lbp3u_pkg::ROW_W-1:0]       out_center_row,
  output logic [lbp3u_pkg::COL_W-1:0]       out_center_col,
  output logic                              out_frame_done
);

  logic                          s1_valid;
  logic [lbp3u_pkg::PIXEL_W-1:0] s1_pixel;
  logic [ADDR_W-1:0]             s1_col;
  lbp3u_pkg::scan_flags_t        s1_flags;
  logic [lbp3u_pkg::ROW_W-1:0]   s1_center_row;
  logic [lbp3u_pkg::COL_W-1:0]   s1_center_col;

  // win[0..2]: column c-2 top/mid/bottom, win[3..5]: column c-1
  logic [lbp3u_pkg::PIXEL_W-1:0] win [6];
  logic [lbp3u_pkg::PIXEL_W-1:0] up, mid, ctr;
  logic [7:0]                    code;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid && s1_flags.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      s1_pixel      <= in_pixel;
      s1_col        <= in_col;
      s1_flags      <= in_flags;
      s1_center_row <= in_center_row;
      s1_center_col <= in_center_col;
    end
  end

  always_comb begin
    up  = mem_rd_data[lbp3u_pkg::LINE_WORD_W-1:lbp3u_pkg::PIXEL_W];
    mid = mem_rd_data[lbp3u_pkg::PIXEL_W-1:0];
    ctr = win[4];
    code[7] = win[0]   >= ctr;
    code[6] = win[3]   >= ctr;
    code[5] = up       >= ctr;
    code[4] = mid      >= ctr;
    code[3] = s1_pixel >= ctr;
    code[2] = win[5]   >= ctr;
    code[1] = win[2]   >= ctr;
    code[0] = win[1]   >= ctr;
  end

  // shift the column up one row in the line store
  assign mem_wr_en   = s1_valid;
  assign mem_wr_addr = s1_col;
  assign mem_wr_data = {mid, s1_pixel};
  assign s1_busy     = s1_valid;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= up;
      win[4] <= mid;
      win[5] <= s1_pixel;
      out_code       <= code;
      out_center_row <= s1_center_row;
      out_center_col <= s1_center_col;
      out_frame_done <= s1_flags.frame_done;
    end
  end

endmodule

>>> rtl/lbp3u_out_queue.sv
// ----------------------------------------------------------------------------
// lbp3u_out_queue
// Small result queue in front of the label channel; absorbs the results in
// flight while the receiver stalls.
// ----------------------------------------------------------------------------
module lbp3u_out_queue (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  lbp3u_pkg::result_t               push_data,
  output logic [lbp3u_pkg::QCOUNT_W-1:0]   count,
  lbp3u_label_if.source                    labels
);

  lbp3u_pkg::result_t              slots [lbp3u_pkg::QUEUE_DEPTH];
  logic [lbp3u_pkg::QPTR_W-1:0]    head, tail;
  logic                            pop;

  assign pop = labels.valid && labels.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + lbp3u_pkg::QPTR_W'(1);
      end
      if (pop) begin
        head <= head + lbp3u_pkg::QPTR_W'(1);
      end
      count <= count + lbp3u_pkg::QCOUNT_W'(push) - lbp3u_pkg::QCOUNT_W'(pop);
    end
  end

  assign labels.valid      = count != '0;
  assign labels.label      = slots[head].label;
  assign labels.center_row = slots[head].center_row;
  assign labels.center_col = slots[head].center_col;
  assign labels.frame_done = slots[head].frame_done;

endmodule

>>> rtl/lbp3u_3x3_uniform_label_stream_unit.sv
// ----------------------------------------------------------------------------
// lbp_3x3_uniform_label_stream_unit
// 3x3 local binary pattern labeller for a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   pixels  : one 8-bit grayscale pixel per transaction in raster order;
//             frame_start on a pixel puts it at row 0, column 0.
//   labels  : one transaction per interior pixel (row and column both >= 1
//             and off the last row/column), in raster order, with the label
//             (uniform 0..58 or raw code), the center position and
//             frame_done on the last label of an image.
//   config  : write_enable/write_index/write_data, written only while idle.
//             Index 0 image_width, 1 image_height, 2 uniform_mode.
// Path: the pixel completing its window goes through the line store read
//   and compare (stage 1), the code register (stage 2) and the table lookup
//   into the queue; labels.valid rises once the queue holds its label.
// Throughput: one pixel per cycle while labels.ready stays high; the line
//   store has one read and one write port and each pixel uses each once.
// Reset: counters go to row 0, column 0, registers to 640 x 480, uniform.
//   Line store and window content is undefined until written.
// Stall: a 4-entry result queue absorbs the pipeline contents; pixels keep
//   flowing until queue plus in-flight items reach 4.
// ----------------------------------------------------------------------------
module lbp_3x3_uniform_label_stream_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               write_enable,
  input  logic [lbp3u_pkg::CFG_INDEX_W-1:0]  write_index,
  input  logic [lbp3u_pkg::CFG_DATA_W-1:0]   write_data,
  lbp3u_pixel_if.sink                        pixels,
  lbp3u_label_if.source                      labels
);

  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // configuration registers
  logic [lbp3u_pkg::WIDTH_W-1:0]  image_width;
  logic [lbp3u_pkg::HEIGHT_W-1:0] image_height;
  logic                           uniform_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lbp3u_pkg::WIDTH_W'(640);
      image_height <= lbp3u_pkg::HEIGHT_W'(480);
      uniform_mode <= 1'b1;
    end else if (write_enable) begin
      unique case (write_index)
        lbp3u_pkg::REG_IMAGE_WIDTH:  image_width  <= write_data[lbp3u_pkg::WIDTH_W-1:0];
        lbp3u_pkg::REG_IMAGE_HEIGHT: image_height <= write_data[lbp3u_pkg::HEIGHT_W-1:0];
        lbp3u_pkg::REG_UNIFORM_MODE: uniform_mode <= write_data[0];
        default: ;
      endcase
    end
  end

  // input handshake: credit covers queue plus both pipeline stages
  logic                           accept;
  logic [lbp3u_pkg::QCOUNT_W-1:0] q_count;
  logic                           s1_busy;
  logic                           s2_valid;
  logic [lbp3u_pkg::QCOUNT_W-1:0] occupancy;

  assign occupancy    = q_count + lbp3u_pkg::QCOUNT_W'(s1_busy)
                      + lbp3u_pkg::QCOUNT_W'(s2_valid);
  assign pixels.ready = occupancy < lbp3u_pkg::QCOUNT_W'(lbp3u_pkg::QUEUE_DEPTH);
  assign accept       = pixels.valid && pixels.ready;

  // stage 0: position and line store read
  logic [ADDR_W-1:0]           s0_col;
  lbp3u_pkg::scan_flags_t      s0_flags;
  logic [lbp3u_pkg::ROW_W-1:0] s0_center_row;
  logic [lbp3u_pkg::COL_W-1:0] s0_center_col;

  lbp3u_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .ADDR_W    (ADDR_W)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .frame_start  (pixels.frame_start),
    .image_width  (image_width),
    .image_height (image_height),
    .col          (s0_col),
    .flags        (s0_flags),
    .center_row   (s0_center_row),
    .center_col   (s0_center_col)
  );

  logic                              mem_wr_en;
  logic [ADDR_W-1:0]                 mem_wr_addr;
  logic [lbp3u_pkg::LINE_WORD_W-1:0] mem_wr_data;
  logic [lbp3u_pkg::LINE_WORD_W-1:0] mem_rd_data;

  lbp3u_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_line_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (accept),
    .rd_addr (s0_col),
    .rd_data (mem_rd_data)
  );

  // stages 1 and 2: window, compare, code register
  logic [7:0]                  s2_code;
  logic [lbp3u_pkg::ROW_W-1:0] s2_center_row;
  logic [lbp3u_pkg::COL_W-1:0] s2_center_col;
  logic                        s2_frame_done;

  lbp3u_window #(
    .ADDR_W (ADDR_W)
  ) u_window (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (accept),
    .in_pixel       (pixels.pixel),
    .in_col         (s0_col),
    .in_flags       (s0_flags),
    .in_center_row  (s0_center_row),
    .in_center_col  (s0_center_col),
    .mem_rd_data    (mem_rd_data),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .s1_busy        (s1_busy),
    .out_valid      (s2_valid),
    .out_code       (s2_code),
    .out_center_row (s2_center_row),
    .out_center_col (s2_center_col),
    .out_frame_done (s2_frame_done)
  );

  // label lookup, then into the result queue
  lbp3u_pkg::result_t push_data;

  always_comb begin
    push_data.label      = uniform_mode ? lbp3u_pkg::LABEL_TABLE[s2_code] : s2_code;
    push_data.center_row = s2_center_row;
    push_data.center_col = s2_center_col;
    push_data.frame_done = s2_frame_done;
  end

  lbp3u_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_data (push_data),
    .count     (q_count),
    .labels    (labels)
  );

endmodule
